// ===== rtl/ftsm_pkg.sv =====
// shared types and constants of the file table scan matcher
// used by ftsm_cell and file_table_scan_matcher_unit, no dependencies
package ftsm_pkg;

  localparam int unsigned MaxKeysDef        = 16;
  localparam int unsigned EntriesPerPageDef = 64;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic        add_en;
    logic        clear;
    logic        match;
    logic        finish;
    logic        shift;
    logic [7:0]  mode;
    logic [7:0]  index;
    logic [15:0] size;
    logic [15:0] usage;
    logic [31:0] run_offset;
    logic [7:0]  pages;
  } cell_cmd_t;

  // one slot report, moved cell to cell toward the output
  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic [15:0] size;
    logic [15:0] usage;
  } report_t;

endpackage

// ===== rtl/file_table_scan_matcher_unit.sv =====
// top level of the file table scan matcher: controller, scan counters, cell chain
// depends on ftsm_pkg and ftsm_cell
//
// The unit keeps a table of up to MAX_KEYS wanted (mode, index) keys, one per
// cell of a chain. Add-key transfers fill the slots in order (ignored once the
// table is full), a clear transfer empties them. Each file table entry of
// nonzero type is offered to all cells in the same cycle; a claim signal runs
// down the chain so the lowest valid, unfound, equal slot takes it and records
// the running offset, size and last-block usage. A new key, clear or entry can
// be taken every cycle while no reports are draining. A type-zero entry closes
// the scan: every key found in this scan gets the pages scanned added to its
// offset, each cell loads its report stage, and MAX_KEYS reports then shift
// out of cell 0 one per cycle while the output is not stalled. While reports
// are draining the input is stalled. Key slots found in an earlier scan are
// still reported as found but are not matched or offset again.
module file_table_scan_matcher_unit #(
  parameter int unsigned MAX_KEYS         = ftsm_pkg::MaxKeysDef,
  parameter int unsigned ENTRIES_PER_PAGE = ftsm_pkg::EntriesPerPageDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  mode_i,
  input  logic [7:0]  index_i,
  input  logic [3:0]  entry_type_i,
  input  logic [15:0] entry_size_i,
  input  logic [15:0] entry_last_usage_i,
  // report channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  slot_o,
  output logic        found_o,
  output logic [31:0] file_offset_o,
  output logic [15:0] file_size_o,
  output logic [15:0] last_usage_o,
  output logic        last_of_run_o
);

  localparam int unsigned CntW  = $clog2(MAX_KEYS + 1);
  localparam int unsigned SlotW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned PageW = $clog2(ENTRIES_PER_PAGE + 1);

  // scan and table counters
  logic [CntW-1:0]  key_count_q, key_count_d;
  logic [31:0]      run_offset_q, run_offset_d;
  logic [PageW-1:0] in_page_q, in_page_d, in_page_inc;
  logic [7:0]       page_count_q, page_count_d;

  // report drain
  logic             drain_q, drain_d;
  logic [SlotW-1:0] rep_cnt_q, rep_cnt_d;

  logic in_xfer, out_xfer, last_rep;
  logic is_entry, is_end;
  ftsm_pkg::action_e action;
  ftsm_pkg::cell_cmd_t cmd;

  logic [MAX_KEYS:0]   claim;
  logic [MAX_KEYS-1:0] take;
  ftsm_pkg::report_t   rep [MAX_KEYS+1];

  assign action    = ftsm_pkg::action_e'(action_i);
  assign in_stall_o = drain_q;
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_valid_o = drain_q;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign last_rep  = (rep_cnt_q == SlotW'(MAX_KEYS - 1));

  assign is_entry  = in_xfer && (action == ftsm_pkg::ACT_ENTRY) && (entry_type_i != 4'd0);
  assign is_end    = in_xfer && (action == ftsm_pkg::ACT_ENTRY) && (entry_type_i == 4'd0);
  assign in_page_inc = in_page_q + PageW'(1);

  // broadcast to the cells
  always_comb begin
    cmd.add_en     = in_xfer && (action == ftsm_pkg::ACT_ADD) &&
                     (key_count_q != CntW'(MAX_KEYS));
    cmd.clear      = in_xfer && (action == ftsm_pkg::ACT_CLEAR);
    cmd.match      = is_entry;
    cmd.finish     = is_end;
    cmd.shift      = out_xfer;
    cmd.mode       = mode_i;
    cmd.index      = index_i;
    cmd.size       = entry_size_i;
    cmd.usage      = entry_last_usage_i;
    cmd.run_offset = run_offset_q;
    cmd.pages      = page_count_q + 8'd1;  // the page holding the end mark counts too
  end

  always_comb begin
    key_count_d  = key_count_q;
    run_offset_d = run_offset_q;
    in_page_d    = in_page_q;
    page_count_d = page_count_q;
    drain_d      = drain_q;
    rep_cnt_d    = rep_cnt_q;
    if (cmd.clear) begin
      key_count_d = '0;
    end else if (cmd.add_en) begin
      key_count_d = key_count_q + CntW'(1);
    end
    if (is_entry) begin
      run_offset_d = run_offset_q + 32'(entry_size_i);
      if (in_page_inc == PageW'(ENTRIES_PER_PAGE)) begin
        in_page_d    = '0;
        page_count_d = page_count_q + 8'd1;
      end else begin
        in_page_d = in_page_inc;
      end
    end else if (is_end) begin
      run_offset_d = '0;
      in_page_d    = '0;
      page_count_d = '0;
      drain_d      = 1'b1;
      rep_cnt_d    = '0;
    end
    if (out_xfer) begin
      rep_cnt_d = rep_cnt_q + SlotW'(1);
      if (last_rep) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q  <= '0;
      run_offset_q <= '0;
      in_page_q    <= '0;
      page_count_q <= '0;
      drain_q      <= 1'b0;
      rep_cnt_q    <= '0;
    end else begin
      key_count_q  <= key_count_d;
      run_offset_q <= run_offset_d;
      in_page_q    <= in_page_d;
      page_count_q <= page_count_d;
      drain_q      <= drain_d;
      rep_cnt_q    <= rep_cnt_d;
    end
  end

  // cell chain: claim ripples toward higher slots, reports shift toward slot 0
  assign claim[0]      = 1'b0;
  assign rep[MAX_KEYS] = '0;

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    ftsm_cell #(
      .Idx (i),
      .CntW(CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .key_count_i(key_count_q),
      .claim_i    (claim[i]),
      .claim_o    (claim[i+1]),
      .take_o     (take[i]),
      .rep_next_i (rep[i+1]),
      .rep_o      (rep[i])
    );
  end

  // report port reads the head of the chain
  assign slot_o        = 4'(rep_cnt_q);
  assign found_o       = rep[0].found;
  assign file_offset_o = rep[0].offset;
  assign file_size_o   = rep[0].size;
  assign last_usage_o  = rep[0].usage;
  assign last_of_run_o = last_rep;

  // at most one slot takes an entry
  a_one_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(take))
    else $error("more than one slot took the same entry");

  // key table never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= CntW'(MAX_KEYS))
    else $error("key count beyond table size");

  // an end mark starts a fresh report run with slot zero
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_end |=> out_valid_o && rep_cnt_q == '0 && run_offset_q == '0)
    else $error("report run did not start cleanly");

  // the final report closes the run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_of_run_o) |=> !out_valid_o)
    else $error("reports continue after the last of the run");

endmodule

// ===== rtl/ftsm_cell.sv =====
// one key slot of the matcher chain: key, match record and report stage
// depends on ftsm_pkg
module ftsm_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftsm_pkg::cell_cmd_t cmd_i,
  input  logic [CntW-1:0]     key_count_i,
  input  logic                claim_i,
  output logic                claim_o,
  output logic                take_o,
  input  ftsm_pkg::report_t   rep_next_i,
  output ftsm_pkg::report_t   rep_o
);

  logic        valid_q, found_q, new_q;
  logic [7:0]  mode_q, index_q;
  logic [31:0] offset_q;
  logic [15:0] size_q, usage_q;
  ftsm_pkg::report_t rep_q;

  logic        hit;
  logic        done;
  logic [31:0] offset_fin;

  assign hit     = cmd_i.match && valid_q && !found_q &&
                   (mode_q == cmd_i.mode) && (index_q == cmd_i.index);
  assign claim_o = claim_i || hit;
  assign take_o  = hit && !claim_i;
  assign done    = valid_q && found_q;
  assign offset_fin = (done && new_q) ? offset_q + 32'(cmd_i.pages) : offset_q;
  assign rep_o   = rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
      new_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
      new_q   <= 1'b0;
    end else if (cmd_i.add_en && key_count_i == CntW'(Idx)) begin
      valid_q <= 1'b1;
      found_q <= 1'b0;
      new_q   <= 1'b0;
    end else if (take_o) begin
      found_q <= 1'b1;
      new_q   <= 1'b1;
    end else if (cmd_i.finish) begin
      new_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en && key_count_i == CntW'(Idx)) begin
      mode_q  <= cmd_i.mode;
      index_q <= cmd_i.index;
    end
    if (take_o) begin
      offset_q <= cmd_i.run_offset;
      size_q   <= cmd_i.size;
      usage_q  <= cmd_i.usage;
    end else if (cmd_i.finish) begin
      offset_q <= offset_fin;
    end
    if (cmd_i.finish) begin
      rep_q.found  <= done;
      rep_q.offset <= done ? offset_fin : 32'd0;
      rep_q.size   <= done ? size_q : 16'd0;
      rep_q.usage  <= done ? usage_q : 16'd0;
    end else if (cmd_i.shift) begin
      rep_q <= rep_next_i;
    end
  end

endmodule
